FILE: design/bcdblk_pkg.sv
`timescale 1ns / 1ps

package bcdblk_pkg;

	// Opcode codes
	localparam logic [4:0] OP_DAA  = 5'd0;
	localparam logic [4:0] OP_RLD  = 5'd1;
	localparam logic [4:0] OP_RRD  = 5'd2;
	localparam logic [4:0] OP_LDI  = 5'd3;
	localparam logic [4:0] OP_LDD  = 5'd4;
	localparam logic [4:0] OP_LDIR = 5'd5;
	localparam logic [4:0] OP_LDDR = 5'd6;
	localparam logic [4:0] OP_CPI  = 5'd7;
	localparam logic [4:0] OP_CPD  = 5'd8;
	localparam logic [4:0] OP_CPIR = 5'd9;
	localparam logic [4:0] OP_CPDR = 5'd10;
	localparam logic [4:0] OP_INI  = 5'd11;
	localparam logic [4:0] OP_IND  = 5'd12;
	localparam logic [4:0] OP_INIR = 5'd13;
	localparam logic [4:0] OP_INDR = 5'd14;
	localparam logic [4:0] OP_OUTI = 5'd15;
	localparam logic [4:0] OP_OUTD = 5'd16;
	localparam logic [4:0] OP_OTIR = 5'd17;
	localparam logic [4:0] OP_OTDR = 5'd18;

	// Write target codes
	localparam logic [1:0] WT_NONE = 2'd0;
	localparam logic [1:0] WT_MEM  = 2'd1;
	localparam logic [1:0] WT_PORT = 2'd2;

	// Flag bit positions
	localparam int unsigned FB_C = 0;
	localparam int unsigned FB_N = 1;
	localparam int unsigned FB_P = 2;
	localparam int unsigned FB_X = 3;
	localparam int unsigned FB_H = 4;
	localparam int unsigned FB_Y = 5;
	localparam int unsigned FB_Z = 6;
	localparam int unsigned FB_S = 7;

	// DAA constants
	localparam logic [7:0] DAA_LIMIT = 8'h99;
	localparam logic [3:0] DAA_NIB   = 4'h6;
	localparam logic [3:0] DAA_DIGIT = 4'h9;

	// One input word
	typedef struct packed {
		logic [4:0]  op;
		logic [7:0]  acc;
		logic [7:0]  flags;
		logic [15:0] bc;
		logic [15:0] de;
		logic [15:0] hl;
		logic [15:0] memptr;
		logic [15:0] pc;
		logic [7:0]  read_byte;
	} item_t;

	// One result word
	typedef struct packed {
		logic [7:0]  acc;
		logic [7:0]  flags;
		logic [15:0] bc;
		logic [15:0] de;
		logic [15:0] hl;
		logic [15:0] memptr;
		logic [15:0] pc;
		logic [1:0]  write_target;
		logic [15:0] write_addr;
		logic [7:0]  write_byte;
		logic        repeat_res;
	} result_t;

	// S Z Y X P from a byte; H, N, C left clear
	function automatic logic [7:0] szyxp(input logic [7:0] v);
		logic [7:0] f;
		f        = 8'h00;
		f[FB_S]  = v[7];
		f[FB_Z]  = (v == 8'h00);
		f[FB_Y]  = v[5];
		f[FB_X]  = v[3];
		f[FB_P]  = ~^v;
		return f;
	endfunction

	// Flags of the block I/O group
	function automatic logic [7:0] io_flags(input logic [7:0] b, input logic [7:0] val,
		input logic [8:0] t);
		logic [7:0] f;
		f        = 8'h00;
		f[FB_S]  = b[7];
		f[FB_Z]  = (b == 8'h00);
		f[FB_Y]  = b[5];
		f[FB_X]  = b[3];
		f[FB_N]  = val[7];
		f[FB_H]  = t[8];
		f[FB_C]  = t[8];
		f[FB_P]  = ~^({5'b00000, t[2:0]} ^ b);
		return f;
	endfunction

endpackage

FILE: design/bcdblk_exec.sv
`timescale 1ns / 1ps

// Execute logic for one instruction word
module bcdblk_exec (
	input  bcdblk_pkg::item_t   item,
	output bcdblk_pkg::result_t res
);
	import bcdblk_pkg::*;

	logic [7:0]  a, f, rb;
	logic [15:0] bc, de, hl, wz, pc;
	logic        up;
	logic        daa_lo, daa_hi;
	logic [7:0]  daa_adj, daa_v;
	logic [7:0]  rld_a, rld_w, rrd_a, rrd_w;
	logic [7:0]  ld_n;
	logic [7:0]  cp_r, cp_r2;
	logic        cp_hc;
	logic [15:0] hl_step, de_step, wz_step, bc_dec;
	logic [7:0]  b_dec, in_k;
	logic [15:0] io_bc, in_wz, out_wz;
	logic [8:0]  in_t, out_t;
	logic        rep;
	logic        is_ldcp;
	result_t     r;

	assign a  = item.acc;
	assign f  = item.flags;
	assign rb = item.read_byte;
	assign bc = item.bc;
	assign de = item.de;
	assign hl = item.hl;
	assign wz = item.memptr;
	assign pc = item.pc;

	// Direction: incrementing forms
	assign up = (item.op == OP_LDI) || (item.op == OP_LDIR) || (item.op == OP_CPI) ||
		(item.op == OP_CPIR) || (item.op == OP_INI) || (item.op == OP_INIR) ||
		(item.op == OP_OUTI) || (item.op == OP_OTIR);

	// Shared pointer steps
	assign hl_step = up ? hl + 16'd1 : hl - 16'd1;
	assign de_step = up ? de + 16'd1 : de - 16'd1;
	assign wz_step = up ? wz + 16'd1 : wz - 16'd1;
	assign bc_dec  = bc - 16'd1;
	assign b_dec   = bc[15:8] - 8'd1;
	assign io_bc   = {b_dec, bc[7:0]};

	// DAA correction
	assign daa_lo  = (a[3:0] > DAA_DIGIT) || f[FB_H];
	assign daa_hi  = (a > DAA_LIMIT) || f[FB_C];
	assign daa_adj = {daa_hi ? DAA_NIB : 4'h0, daa_lo ? DAA_NIB : 4'h0};
	assign daa_v   = f[FB_N] ? a - daa_adj : a + daa_adj;

	// Nibble rotates
	assign rld_a = {a[7:4], rb[7:4]};
	assign rld_w = {rb[3:0], a[3:0]};
	assign rrd_a = {a[7:4], rb[3:0]};
	assign rrd_w = {a[3:0], rb[7:4]};

	// Transfer and compare sums
	assign ld_n  = rb + a;
	assign cp_r  = a - rb;
	assign cp_hc = (a[3:0] < rb[3:0]);
	assign cp_r2 = cp_hc ? cp_r - 8'd1 : cp_r;

	// Block I/O sums
	assign in_k   = up ? bc[7:0] + 8'd1 : bc[7:0] - 8'd1;
	assign in_wz  = up ? bc + 16'd1 : bc - 16'd1;
	assign out_wz = up ? io_bc + 16'd1 : io_bc - 16'd1;
	assign in_t   = {1'b0, in_k} + {1'b0, rb};
	assign out_t  = {1'b0, hl_step[7:0]} + {1'b0, rb};

	assign is_ldcp = (item.op <= OP_CPDR);

	// Per-opcode result
	always_comb begin
		r.acc          = a;
		r.flags        = f;
		r.bc           = bc;
		r.de           = de;
		r.hl           = hl;
		r.memptr       = wz;
		r.pc           = pc;
		r.write_target = WT_NONE;
		r.write_addr   = 16'h0000;
		r.write_byte   = 8'h00;
		rep            = 1'b0;
		case (item.op)
			OP_DAA: begin
				r.acc          = daa_v;
				r.flags        = szyxp(daa_v);
				r.flags[FB_N]  = f[FB_N];
				r.flags[FB_C]  = f[FB_C] | (a > DAA_LIMIT);
				r.flags[FB_H]  = a[4] ^ daa_v[4];
			end
			OP_RLD, OP_RRD: begin
				r.acc          = (item.op == OP_RLD) ? rld_a : rrd_a;
				r.write_byte   = (item.op == OP_RLD) ? rld_w : rrd_w;
				r.write_target = WT_MEM;
				r.write_addr   = hl;
				r.memptr       = hl + 16'd1;
				r.flags        = szyxp(r.acc);
				r.flags[FB_C]  = f[FB_C];
			end
			OP_LDI, OP_LDD, OP_LDIR, OP_LDDR: begin
				r.write_target = WT_MEM;
				r.write_addr   = de;
				r.write_byte   = rb;
				r.hl           = hl_step;
				r.de           = de_step;
				r.bc           = bc_dec;
				r.flags        = 8'h00;
				r.flags[FB_S]  = f[FB_S];
				r.flags[FB_Z]  = f[FB_Z];
				r.flags[FB_C]  = f[FB_C];
				r.flags[FB_Y]  = ld_n[1];
				r.flags[FB_X]  = ld_n[3];
				r.flags[FB_P]  = (bc_dec != 16'h0000);
				rep            = ((item.op == OP_LDIR) || (item.op == OP_LDDR)) &&
					(bc_dec != 16'h0000);
			end
			OP_CPI, OP_CPD, OP_CPIR, OP_CPDR: begin
				r.memptr       = wz_step;
				r.hl           = hl_step;
				r.bc           = bc_dec;
				r.flags        = 8'h00;
				r.flags[FB_N]  = 1'b1;
				r.flags[FB_C]  = f[FB_C];
				r.flags[FB_S]  = cp_r[7];
				r.flags[FB_Z]  = (cp_r == 8'h00);
				r.flags[FB_H]  = cp_hc;
				r.flags[FB_Y]  = cp_r2[1];
				r.flags[FB_X]  = cp_r2[3];
				r.flags[FB_P]  = (bc_dec != 16'h0000);
				rep            = ((item.op == OP_CPIR) || (item.op == OP_CPDR)) &&
					(bc_dec != 16'h0000) && (cp_r != 8'h00);
			end
			OP_INI, OP_IND, OP_INIR, OP_INDR: begin
				r.write_target = WT_MEM;
				r.write_addr   = hl;
				r.write_byte   = rb;
				r.memptr       = in_wz;
				r.bc           = io_bc;
				r.hl           = hl_step;
				r.flags        = io_flags(b_dec, rb, in_t);
				rep            = ((item.op == OP_INIR) || (item.op == OP_INDR)) &&
					(b_dec != 8'h00);
			end
			OP_OUTI, OP_OUTD, OP_OTIR, OP_OTDR: begin
				r.write_target = WT_PORT;
				r.write_addr   = io_bc;
				r.write_byte   = rb;
				r.memptr       = out_wz;
				r.bc           = io_bc;
				r.hl           = hl_step;
				r.flags        = io_flags(b_dec, rb, out_t);
				rep            = ((item.op == OP_OTIR) || (item.op == OP_OTDR)) &&
					(b_dec != 8'h00);
			end
			default: begin
				// unused codes pass everything through
				rep = 1'b0;
			end
		endcase

		// Repeat: back up PC over the two opcode bytes
		r.repeat_res = rep;
		if (rep) begin
			r.pc = pc - 16'd2;
			if (is_ldcp) begin
				r.memptr = pc - 16'd1;
			end
		end
	end

	assign res = r;

endmodule

FILE: design/bcd_adjust_and_block_op_execute_core.sv
`timescale 1ns / 1ps

// Done is registered: a taken start sets the input valid flag, which in turn sets
// done in the result register. Throughput: one word per cycle, busy is always low.
// One input register and one result register with the execute logic between.
// The receiver cannot stall: each result is shown for exactly one cycle.
// Reset (arst_n low, asynchronous) clears the valid and done flags only.
module bcd_adjust_and_block_op_execute_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [4:0]  op,
	input  logic [7:0]  acc_in,
	input  logic [7:0]  flags_in,
	input  logic [15:0] bc_in,
	input  logic [15:0] de_in,
	input  logic [15:0] hl_in,
	input  logic [15:0] memptr_in,
	input  logic [15:0] pc_in,
	input  logic [7:0]  read_byte,
	output logic        done,
	output logic [7:0]  acc_out,
	output logic [7:0]  flags_out,
	output logic [15:0] bc_out,
	output logic [15:0] de_out,
	output logic [15:0] hl_out,
	output logic [15:0] memptr_out,
	output logic [15:0] pc_out,
	output logic [1:0]  write_target,
	output logic [15:0] write_addr,
	output logic [7:0]  write_byte,
	output logic        repeat_res
);
	import bcdblk_pkg::*;

	item_t   item_s1;
	logic    vld_s1;
	result_t exec_res;
	result_t res_q;
	logic    done_q;

	assign busy = 1'b0;

	// Input register: valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	// Input register: payload
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			item_s1.op        <= op;
			item_s1.acc       <= acc_in;
			item_s1.flags     <= flags_in;
			item_s1.bc        <= bc_in;
			item_s1.de        <= de_in;
			item_s1.hl        <= hl_in;
			item_s1.memptr    <= memptr_in;
			item_s1.pc        <= pc_in;
			item_s1.read_byte <= read_byte;
		end
	end

	bcdblk_exec u_exec (
		.item (item_s1),
		.res  (exec_res)
	);

	// Result register: strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_s1;
		end
	end

	// Result register: payload
	always_ff @(posedge clk) begin
		if (vld_s1) begin
			res_q <= exec_res;
		end
	end

	assign done         = done_q;
	assign acc_out      = res_q.acc;
	assign flags_out    = res_q.flags;
	assign bc_out       = res_q.bc;
	assign de_out       = res_q.de;
	assign hl_out       = res_q.hl;
	assign memptr_out   = res_q.memptr;
	assign pc_out       = res_q.pc;
	assign write_target = res_q.write_target;
	assign write_addr   = res_q.write_addr;
	assign write_byte   = res_q.write_byte;
	assign repeat_res   = res_q.repeat_res;

endmodule
